[design/bmp24_stream_to_pixels_macros.svh]
// Assertion macros shared by the decoder modules.
`ifndef BMP24_STREAM_TO_PIXELS_MACROS_SVH
`define BMP24_STREAM_TO_PIXELS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMP24_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bmp24 same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMP24_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bmp24 next-cycle check failed");

`endif

[design/bmp24_pkg.sv]
// Types and constants shared by the BMP decoder modules.
package bmp24_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
    localparam logic [2:0] ERR_SIGNATURE    = 3'd2;
    localparam logic [2:0] ERR_DEPTH        = 3'd3;
    localparam logic [2:0] ERR_COMPRESSED   = 3'd4;
    localparam logic [2:0] ERR_DIMENSIONS   = 3'd5;
    localparam logic [2:0] ERR_OFFSET       = 3'd6;
    localparam logic [2:0] ERR_SHORT_DATA   = 3'd7;

    localparam int          HDR_BYTES = 54;
    localparam logic [15:0] SIGNATURE = 16'h4D42;
    localparam logic [15:0] BIT_DEPTH = 16'd24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] column;
        logic [12:0] row;
        logic [23:0] pixel_index;
        logic [2:0]  error_code;
        logic        last_pixel;
    } result_t;

    // At most one queue entry per input byte; a short-data error may trail the result.
    typedef struct packed {
        result_t res;
        logic    add_short_data;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[design/bmp24_front.sv]
// Byte parser: header capture and checks, skip, pixel assembly and row padding.
`include "bmp24_stream_to_pixels_macros.svh"

module bmp24_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_file_byte,
    input  logic                s_end_of_file,
    input  bmp24_pkg::q_status_t q_status,
    output logic                push_valid,
    output bmp24_pkg::entry_t   push_entry
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = (WW + HW > 24) ? (WW + HW) : 24;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXELS = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    logic [2:0]    phase_reg, phase_next;
    logic [31:0]   pos_reg, pos_next;
    logic [15:0]   sig_reg, sig_next;
    logic [31:0]   offset_reg, offset_next;
    logic [31:0]   width_reg, width_next;
    logic [31:0]   height_reg, height_next;
    logic [15:0]   depth_reg, depth_next;
    logic [31:0]   comp_reg, comp_next;
    logic          bottom_up_reg, bottom_up_next;
    logic [WW-1:0] col_reg, col_next;
    logic [HW-1:0] src_reg, src_next;
    logic [HW-1:0] dest_reg, dest_next;
    logic [23:0]   base_reg, base_next;
    logic [1:0]    bip_reg, bip_next;
    logic [1:0]    pad_reg, pad_next;
    logic [7:0]    blue_reg, blue_next;
    logic [7:0]    green_reg, green_next;

    // Derived header values, settled long before the last header byte arrives.
    logic [31:0]   hmag_reg, hmag_next;
    logic [2:0]    hdr_err_reg, hdr_err_next;
    logic [23:0]   product_reg;
    logic [PW-1:0] product_full;

    logic          accept;
    logic [WW-1:0] width_w;
    logic [HW-1:0] hmag_h;
    logic [HW-1:0] hmag_m1;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] src_inc;
    logic [1:0]    pad_inc;
    logic [31:0]   pos_inc;
    logic          start_row;
    logic          next_row;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    assign width_w = width_reg[WW-1:0];
    assign hmag_h  = hmag_reg[HW-1:0];
    assign hmag_m1 = hmag_h - 1'b1;
    assign col_inc = col_reg + 1'b1;
    assign src_inc = src_reg + 1'b1;
    assign pad_inc = pad_reg + 2'd1;
    assign pos_inc = pos_reg + 32'd1;

    assign hmag_next    = height_reg[31] ? (32'd0 - height_reg) : height_reg;
    assign product_full = PW'(width_w) * PW'(hmag_m1);

    always_comb begin
        if (sig_reg != bmp24_pkg::SIGNATURE) begin
            hdr_err_next = bmp24_pkg::ERR_SIGNATURE;
        end else if (depth_reg != bmp24_pkg::BIT_DEPTH) begin
            hdr_err_next = bmp24_pkg::ERR_DEPTH;
        end else if (comp_reg != 32'd0) begin
            hdr_err_next = bmp24_pkg::ERR_COMPRESSED;
        end else if (width_reg == 32'd0 || width_reg > 32'(MAX_WIDTH)) begin
            hdr_err_next = bmp24_pkg::ERR_DIMENSIONS;
        end else if (hmag_reg == 32'd0 || hmag_reg > 32'(MAX_HEIGHT)) begin
            hdr_err_next = bmp24_pkg::ERR_DIMENSIONS;
        end else if (offset_reg < 32'(bmp24_pkg::HDR_BYTES)) begin
            hdr_err_next = bmp24_pkg::ERR_OFFSET;
        end else begin
            hdr_err_next = bmp24_pkg::ERR_NONE;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        sig_next       = sig_reg;
        offset_next    = offset_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        depth_next     = depth_reg;
        comp_next      = comp_reg;
        bottom_up_next = bottom_up_reg;
        col_next       = col_reg;
        src_next       = src_reg;
        dest_next      = dest_reg;
        base_next      = base_reg;
        bip_next       = bip_reg;
        pad_next       = pad_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        push_valid     = 1'b0;
        push_entry     = '0;
        start_row      = 1'b0;
        next_row       = 1'b0;

        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    pos_next = pos_inc;
                    unique case (pos_reg[5:0])
                        6'd0:  sig_next[7:0]      = s_file_byte;
                        6'd1:  sig_next[15:8]     = s_file_byte;
                        6'd10: offset_next[7:0]   = s_file_byte;
                        6'd11: offset_next[15:8]  = s_file_byte;
                        6'd12: offset_next[23:16] = s_file_byte;
                        6'd13: offset_next[31:24] = s_file_byte;
                        6'd18: width_next[7:0]    = s_file_byte;
                        6'd19: width_next[15:8]   = s_file_byte;
                        6'd20: width_next[23:16]  = s_file_byte;
                        6'd21: width_next[31:24]  = s_file_byte;
                        6'd22: height_next[7:0]   = s_file_byte;
                        6'd23: height_next[15:8]  = s_file_byte;
                        6'd24: height_next[23:16] = s_file_byte;
                        6'd25: height_next[31:24] = s_file_byte;
                        6'd28: depth_next[7:0]    = s_file_byte;
                        6'd29: depth_next[15:8]   = s_file_byte;
                        6'd30: comp_next[7:0]     = s_file_byte;
                        6'd31: comp_next[15:8]    = s_file_byte;
                        6'd32: comp_next[23:16]   = s_file_byte;
                        6'd33: comp_next[31:24]   = s_file_byte;
                        default: ;
                    endcase
                    if (pos_reg == 32'(bmp24_pkg::HDR_BYTES - 1)) begin
                        push_valid = 1'b1;
                        if (hdr_err_reg != bmp24_pkg::ERR_NONE) begin
                            push_entry.res.kind       = bmp24_pkg::KIND_ERROR;
                            push_entry.res.error_code = hdr_err_reg;
                            phase_next                = PH_ERROR;
                        end else begin
                            bottom_up_next        = !height_reg[31];
                            push_entry.res.kind   = bmp24_pkg::KIND_HEADER;
                            push_entry.res.column = width_reg[12:0];
                            push_entry.res.row    = hmag_reg[12:0];
                            src_next              = '0;
                            if (offset_reg == 32'(bmp24_pkg::HDR_BYTES)) begin
                                start_row = 1'b1;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end else if (s_end_of_file) begin
                        push_valid                = 1'b1;
                        push_entry.res.kind       = bmp24_pkg::KIND_ERROR;
                        push_entry.res.error_code = bmp24_pkg::ERR_SHORT_HEADER;
                        phase_next                = PH_ERROR;
                    end
                end
                PH_SKIP: begin
                    pos_next = pos_inc;
                    if (pos_inc == offset_reg) begin
                        start_row = 1'b1;
                    end
                end
                PH_PIXELS: begin
                    unique case (bip_reg)
                        2'd0: begin
                            blue_next = s_file_byte;
                            bip_next  = 2'd1;
                        end
                        2'd1: begin
                            green_next = s_file_byte;
                            bip_next   = 2'd2;
                        end
                        default: begin
                            push_valid                 = 1'b1;
                            push_entry.res.kind        = bmp24_pkg::KIND_PIXEL;
                            push_entry.res.red         = s_file_byte;
                            push_entry.res.green       = green_reg;
                            push_entry.res.blue        = blue_reg;
                            push_entry.res.column      = 13'(col_reg);
                            push_entry.res.row         = 13'(dest_reg);
                            push_entry.res.pixel_index = base_reg + 24'(col_reg);
                            push_entry.res.last_pixel  = (src_inc == hmag_h) &&
                                                         (col_inc == width_w);
                            bip_next = 2'd0;
                            col_next = col_inc;
                            if (col_inc >= width_w) begin
                                if (width_reg[1:0] == 2'd0) begin
                                    next_row = 1'b1;
                                end else begin
                                    pad_next   = 2'd0;
                                    phase_next = PH_PAD;
                                end
                            end
                        end
                    endcase
                end
                PH_PAD: begin
                    pad_next = pad_inc;
                    if (pad_inc >= width_reg[1:0]) begin
                        next_row = 1'b1;
                    end
                end
                default: ;
            endcase

            // Rows advance by one width; bottom-up files fill from the last row.
            if (next_row) begin
                src_next = src_inc;
                if (src_inc >= hmag_h) begin
                    phase_next = PH_DONE;
                end else begin
                    base_next  = bottom_up_reg ? (base_reg - 24'(width_w))
                                               : (base_reg + 24'(width_w));
                    dest_next  = bottom_up_reg ? (dest_reg - 1'b1) : (dest_reg + 1'b1);
                    col_next   = '0;
                    bip_next   = 2'd0;
                    pad_next   = 2'd0;
                    phase_next = PH_PIXELS;
                end
            end

            if (start_row) begin
                base_next  = bottom_up_next ? product_reg : 24'd0;
                dest_next  = bottom_up_next ? hmag_m1 : '0;
                col_next   = '0;
                bip_next   = 2'd0;
                pad_next   = 2'd0;
                phase_next = PH_PIXELS;
            end

            if (s_end_of_file && (phase_next == PH_SKIP || phase_next == PH_PIXELS ||
                                  phase_next == PH_PAD)) begin
                if (push_valid) begin
                    push_entry.add_short_data = 1'b1;
                end else begin
                    push_valid                = 1'b1;
                    push_entry.res.kind       = bmp24_pkg::KIND_ERROR;
                    push_entry.res.error_code = bmp24_pkg::ERR_SHORT_DATA;
                end
                phase_next = PH_ERROR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= 32'd0;
            bottom_up_reg <= 1'b0;
            col_reg       <= '0;
            src_reg       <= '0;
            bip_reg       <= 2'd0;
            pad_reg       <= 2'd0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            bottom_up_reg <= bottom_up_next;
            col_reg       <= col_next;
            src_reg       <= src_next;
            bip_reg       <= bip_next;
            pad_reg       <= pad_next;
        end
    end

    always_ff @(posedge aclk) begin
        sig_reg     <= sig_next;
        offset_reg  <= offset_next;
        width_reg   <= width_next;
        height_reg  <= height_next;
        depth_reg   <= depth_next;
        comp_reg    <= comp_next;
        dest_reg    <= dest_next;
        base_reg    <= base_next;
        blue_reg    <= blue_next;
        green_reg   <= green_next;
        hmag_reg    <= hmag_next;
        hdr_err_reg <= hdr_err_next;
        product_reg <= product_full[23:0];
    end

    `BMP24_ASSERT_IMPLIES(a_silent_when_finished, aclk, aresetn,
        phase_reg == PH_ERROR || phase_reg == PH_DONE, !push_valid)
    `BMP24_ASSERT_IMPLIES(a_pixel_on_third_byte, aclk, aresetn,
        push_valid && push_entry.res.kind == bmp24_pkg::KIND_PIXEL,
        phase_reg == PH_PIXELS && bip_reg == 2'd2)

endmodule

[design/bmp24_queue.sv]
// Short result queue between the byte parser and the output stage.
`include "bmp24_stream_to_pixels_macros.svh"

module bmp24_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  bmp24_pkg::entry_t    push_entry,
    input  logic                 pop,
    output bmp24_pkg::entry_t    head_entry,
    output bmp24_pkg::q_status_t q_status
);

    bmp24_pkg::entry_t                    mem_reg [bmp24_pkg::QUEUE_DEPTH];
    logic [bmp24_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [bmp24_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [bmp24_pkg::QPTR_W:0]           count_reg;

    assign head_entry     = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == (bmp24_pkg::QPTR_W + 1)'(bmp24_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push_valid, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `BMP24_ASSERT_IMPLIES(a_no_push_when_full, aclk, aresetn, q_status.full, !push_valid)
    `BMP24_ASSERT_IMPLIES(a_no_pop_when_empty, aclk, aresetn, q_status.empty, !pop)
    `BMP24_ASSERT_NEXT(a_count_tracks_push, aclk, aresetn, push_valid && !pop,
        count_reg == $past(count_reg) + 1'b1)

endmodule

[design/bmp24_back.sv]
// Output stage: pops queue entries and presents one result per cycle while m_ready is high.
`include "bmp24_stream_to_pixels_macros.svh"

module bmp24_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bmp24_pkg::q_status_t q_status,
    input  bmp24_pkg::entry_t    head_entry,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [7:0]           m_red,
    output logic [7:0]           m_green,
    output logic [7:0]           m_blue,
    output logic [12:0]          m_column,
    output logic [12:0]          m_row,
    output logic [23:0]          m_pixel_index,
    output logic [2:0]           m_error_code,
    output logic                 m_last_pixel,
    output logic                 m_end_of_run
);

    logic               valid_reg, valid_next;
    logic               pending_reg, pending_next;
    logic               eor_reg, eor_next;
    bmp24_pkg::result_t out_reg, out_next;
    logic               load;

    assign load = !valid_reg || m_ready;

    always_comb begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        eor_next     = eor_reg;
        out_next     = out_reg;
        pop          = 1'b0;
        if (load) begin
            if (pending_reg) begin
                // The short-data error that trails the result just delivered.
                out_next            = '0;
                out_next.kind       = bmp24_pkg::KIND_ERROR;
                out_next.error_code = bmp24_pkg::ERR_SHORT_DATA;
                eor_next            = 1'b1;
                pending_next        = 1'b0;
                valid_next          = 1'b1;
            end else if (!q_status.empty) begin
                pop          = 1'b1;
                out_next     = head_entry.res;
                eor_next     = !head_entry.add_short_data;
                pending_next = head_entry.add_short_data;
                valid_next   = 1'b1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        eor_reg <= eor_next;
    end

    assign m_valid       = valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_red         = out_reg.red;
    assign m_green       = out_reg.green;
    assign m_blue        = out_reg.blue;
    assign m_column      = out_reg.column;
    assign m_row         = out_reg.row;
    assign m_pixel_index = out_reg.pixel_index;
    assign m_error_code  = out_reg.error_code;
    assign m_last_pixel  = out_reg.last_pixel;
    assign m_end_of_run  = eor_reg;

    `BMP24_ASSERT_IMPLIES(a_pending_follows_first, aclk, aresetn, pending_reg,
        valid_reg && !eor_reg)

endmodule

[design/bmp24_stream_to_pixels.sv]
// Top level of the byte-serial 24-bit BMP decoder.
//
// Input channel (s_): one file byte per request, s_end_of_file marks the last
// byte. Result channel (m_): header, pixel and error results; m_end_of_run is
// set on the last result caused by a byte. A byte causes at most two results.
// The first 54 bytes are the headers; on the 54th the header is checked and
// either a header result or an error is sent. Bytes up to the data offset are
// skipped, then every third pixel byte yields an RGB pixel with its top-down
// row, column and index. After an error or the final row, bytes are consumed
// silently until reset.
// Throughput: one byte per cycle while s_ready is high. A result passes from
// the parser into a four-entry queue, then the output register; a byte
// with two results presents them on the output one after the other.
// When the receiver stalls, results collect in the queue and s_ready falls
// once the queue holds four entries.
// Reset (aresetn low, synchronous) empties the queue and output register and
// restarts header parsing at byte zero.
module bmp24_stream_to_pixels #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_end_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [12:0] m_column,
    output logic [12:0] m_row,
    output logic [23:0] m_pixel_index,
    output logic [2:0]  m_error_code,
    output logic        m_last_pixel,
    output logic        m_end_of_run
);

    logic                 push_valid;
    bmp24_pkg::entry_t    push_entry;
    bmp24_pkg::entry_t    head_entry;
    bmp24_pkg::q_status_t q_status;
    logic                 pop;

    bmp24_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_file_byte   (s_file_byte),
        .s_end_of_file (s_end_of_file),
        .q_status      (q_status),
        .push_valid    (push_valid),
        .push_entry    (push_entry)
    );

    bmp24_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    bmp24_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_column      (m_column),
        .m_row         (m_row),
        .m_pixel_index (m_pixel_index),
        .m_error_code  (m_error_code),
        .m_last_pixel  (m_last_pixel),
        .m_end_of_run  (m_end_of_run)
    );

endmodule

[dv/bmp24_stream_to_pixels_checker.sv]
// Checker for the BMP decoder: predicts every result from the accepted bytes and compares.
`timescale 1ns / 1ps

module bmp24_stream_to_pixels_checker #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_end_of_file,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [7:0]  m_red,
    input  logic [7:0]  m_green,
    input  logic [7:0]  m_blue,
    input  logic [12:0] m_column,
    input  logic [12:0] m_row,
    input  logic [23:0] m_pixel_index,
    input  logic [2:0]  m_error_code,
    input  logic        m_last_pixel,
    input  logic        m_end_of_run,
    output int          mismatch_count,
    output int          outstanding,
    output int          results_checked
);

    typedef enum logic [2:0] {
        DEC_HEADER,
        DEC_SKIP,
        DEC_PIXELS,
        DEC_PAD,
        DEC_DONE,
        DEC_ERROR
    } dec_phase_e;

    typedef struct packed {
        bmp24_pkg::result_t res;
        logic               end_of_run;
    } pixel_result_t;

    pixel_result_t pixel_results[$];
    pixel_result_t want;

    dec_phase_e  dec_phase;
    logic [31:0] byte_pos;
    logic [15:0] sig_word;
    logic [31:0] data_offset;
    logic [31:0] raw_width;
    logic [31:0] raw_height;
    logic [15:0] bit_depth;
    logic [31:0] compression;
    logic        bottom_up;
    logic [31:0] col_count;
    logic [31:0] src_row;
    logic [1:0]  byte_in_pixel;
    logic [31:0] pad_count;
    logic [7:0]  held_blue;
    logic [7:0]  held_green;
    logic [23:0] row_base;

    function automatic logic [31:0] image_height();
        return raw_height[31] ? 32'd0 - raw_height : raw_height;
    endfunction

    function automatic logic [31:0] dest_row();
        return bottom_up ? image_height() - 32'd1 - src_row : src_row;
    endfunction

    function automatic bmp24_pkg::result_t error_result(input logic [2:0] code);
        bmp24_pkg::result_t r;
        r            = '0;
        r.kind       = bmp24_pkg::KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    task automatic queue_result(input bmp24_pkg::result_t r);
        pixel_results.push_back({r, 1'b0});
    endtask

    task automatic begin_row();
        row_base      = 24'(dest_row() * raw_width);
        col_count     = 32'd0;
        byte_in_pixel = 2'd0;
        pad_count     = 32'd0;
        dec_phase     = DEC_PIXELS;
    endtask

    task automatic finish_row();
        src_row = src_row + 32'd1;
        if (src_row >= image_height()) begin
            dec_phase = DEC_DONE;
        end else begin
            begin_row();
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic eof);
        int                 first_new;
        logic [2:0]         code;
        logic [31:0]        h;
        bmp24_pkg::result_t r;
        pixel_result_t      tail;
        first_new = pixel_results.size();
        case (dec_phase)
            DEC_HEADER: begin
                if (byte_pos < 2)
                    sig_word[8*byte_pos +: 8] = b;
                else if (byte_pos >= 10 && byte_pos < 14)
                    data_offset[8*(byte_pos-10) +: 8] = b;
                else if (byte_pos >= 18 && byte_pos < 22)
                    raw_width[8*(byte_pos-18) +: 8] = b;
                else if (byte_pos >= 22 && byte_pos < 26)
                    raw_height[8*(byte_pos-22) +: 8] = b;
                else if (byte_pos >= 28 && byte_pos < 30)
                    bit_depth[8*(byte_pos-28) +: 8] = b;
                else if (byte_pos >= 30 && byte_pos < 34)
                    compression[8*(byte_pos-30) +: 8] = b;
                byte_pos = byte_pos + 32'd1;
                if (byte_pos == bmp24_pkg::HDR_BYTES) begin
                    h    = image_height();
                    code = bmp24_pkg::ERR_NONE;
                    if (sig_word != bmp24_pkg::SIGNATURE)
                        code = bmp24_pkg::ERR_SIGNATURE;
                    else if (bit_depth != bmp24_pkg::BIT_DEPTH)
                        code = bmp24_pkg::ERR_DEPTH;
                    else if (compression != 0)
                        code = bmp24_pkg::ERR_COMPRESSED;
                    else if (raw_width < 1 || raw_width > MAX_WIDTH ||
                             h < 1 || h > MAX_HEIGHT)
                        code = bmp24_pkg::ERR_DIMENSIONS;
                    else if (data_offset < bmp24_pkg::HDR_BYTES)
                        code = bmp24_pkg::ERR_OFFSET;
                    if (code != bmp24_pkg::ERR_NONE) begin
                        queue_result(error_result(code));
                        dec_phase = DEC_ERROR;
                    end else begin
                        bottom_up = !raw_height[31];
                        r         = '0;
                        r.kind    = bmp24_pkg::KIND_HEADER;
                        r.column  = raw_width[12:0];
                        r.row     = h[12:0];
                        queue_result(r);
                        src_row = 32'd0;
                        if (data_offset == bmp24_pkg::HDR_BYTES)
                            begin_row();
                        else
                            dec_phase = DEC_SKIP;
                    end
                end else if (eof) begin
                    queue_result(error_result(bmp24_pkg::ERR_SHORT_HEADER));
                    dec_phase = DEC_ERROR;
                end
            end
            DEC_SKIP: begin
                byte_pos = byte_pos + 32'd1;
                if (byte_pos == data_offset)
                    begin_row();
            end
            DEC_PIXELS: begin
                if (byte_in_pixel == 2'd0) begin
                    held_blue     = b;
                    byte_in_pixel = 2'd1;
                end else if (byte_in_pixel == 2'd1) begin
                    held_green    = b;
                    byte_in_pixel = 2'd2;
                end else begin
                    r             = '0;
                    r.kind        = bmp24_pkg::KIND_PIXEL;
                    r.red         = b;
                    r.green       = held_green;
                    r.blue        = held_blue;
                    r.column      = col_count[12:0];
                    r.row         = 13'(dest_row());
                    r.pixel_index = 24'(row_base + col_count);
                    r.last_pixel  = (src_row + 1 == image_height()) &&
                                    (col_count + 1 == raw_width);
                    queue_result(r);
                    byte_in_pixel = 2'd0;
                    col_count     = col_count + 32'd1;
                    if (col_count >= raw_width) begin
                        if (raw_width[1:0] == 2'd0) begin
                            finish_row();
                        end else begin
                            pad_count = 32'd0;
                            dec_phase = DEC_PAD;
                        end
                    end
                end
            end
            DEC_PAD: begin
                pad_count = pad_count + 32'd1;
                if (pad_count >= raw_width[1:0])
                    finish_row();
            end
            default: begin
            end
        endcase

        // A file that stops before the last row's padding is short, even when
        // the final byte also completed a pixel.
        if (eof && (dec_phase == DEC_SKIP || dec_phase == DEC_PIXELS ||
                    dec_phase == DEC_PAD)) begin
            queue_result(error_result(bmp24_pkg::ERR_SHORT_DATA));
            dec_phase = DEC_ERROR;
        end

        if (pixel_results.size() > first_new) begin
            tail            = pixel_results.pop_back();
            tail.end_of_run = 1'b1;
            pixel_results.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input logic [23:0] want_v,
                               input logic [23:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pixel_results.delete();
            mismatch_count  = 0;
            results_checked = 0;
            dec_phase       = DEC_HEADER;
            byte_pos        = '0;
            sig_word        = '0;
            data_offset     = '0;
            raw_width       = '0;
            raw_height      = '0;
            bit_depth       = '0;
            compression     = '0;
            bottom_up       = 1'b0;
            col_count       = '0;
            src_row         = '0;
            byte_in_pixel   = '0;
            pad_count       = '0;
            held_blue       = '0;
            held_green      = '0;
            row_base        = '0;
        end else begin
            // A result never leaves in the cycle its byte is accepted, so the
            // output side is checked before this cycle's byte is predicted.
            if (m_valid && m_ready) begin
                results_checked = results_checked + 1;
                if (pixel_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual kind %0d",
                             $time, m_kind);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = pixel_results.pop_front();
                    check_field("kind", 24'(want.res.kind), 24'(m_kind));
                    check_field("red", 24'(want.res.red), 24'(m_red));
                    check_field("green", 24'(want.res.green), 24'(m_green));
                    check_field("blue", 24'(want.res.blue), 24'(m_blue));
                    check_field("column", 24'(want.res.column), 24'(m_column));
                    check_field("row", 24'(want.res.row), 24'(m_row));
                    check_field("pixel_index", want.res.pixel_index, m_pixel_index);
                    check_field("error_code", 24'(want.res.error_code),
                                24'(m_error_code));
                    check_field("last_pixel", 24'(want.res.last_pixel),
                                24'(m_last_pixel));
                    check_field("end_of_run", 24'(want.end_of_run), 24'(m_end_of_run));
                end
            end
            if (s_valid && s_ready)
                predict_byte(s_file_byte, s_end_of_file);
        end
        outstanding <= pixel_results.size();
    end

endmodule

[dv/bmp24_stream_to_pixels_tb.sv]
// Testbench top for the BMP decoder: builds one random BMP file stream and reports the verdict.
`timescale 1ns / 1ps

module bmp24_stream_to_pixels_tb;

    localparam int QUIET_LIMIT = 5000;
    localparam int DATA_BUDGET = 1900;

    typedef enum int {
        FILE_TRAILING,
        FILE_EXACT,
        FILE_SHORT
    } file_end_e;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_file_byte   = 8'h00;
    logic        s_end_of_file = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [12:0] m_column;
    logic [12:0] m_row;
    logic [23:0] m_pixel_index;
    logic [2:0]  m_error_code;
    logic        m_last_pixel;
    logic        m_end_of_run;

    int   mismatch_count;
    int   outstanding;
    int   results_checked;
    int   bytes_sent    = 0;
    int   planned_bytes = 1;
    int   tx_idle_pct   = 0;
    int   rx_idle_pct   = 0;
    int   quiet_cycles  = 0;
    logic stim_done     = 1'b0;

    bmp24_stream_to_pixels u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_file_byte   (s_file_byte),
        .s_end_of_file (s_end_of_file),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_column      (m_column),
        .m_row         (m_row),
        .m_pixel_index (m_pixel_index),
        .m_error_code  (m_error_code),
        .m_last_pixel  (m_last_pixel),
        .m_end_of_run  (m_end_of_run)
    );

    bmp24_stream_to_pixels_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_end_of_file   (s_end_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_column        (m_column),
        .m_row           (m_row),
        .m_pixel_index   (m_pixel_index),
        .m_error_code    (m_error_code),
        .m_last_pixel    (m_last_pixel),
        .m_end_of_run    (m_end_of_run),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (stim_done && outstanding == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("bmp24_stream_to_pixels_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The first third of the file runs with a slow receiver, the second with
    // a slow sender, the last third without idling.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (bytes_sent < planned_bytes / 3) begin
            tx_idle_pct = 34;
            rx_idle_pct <= 56;
        end else if (bytes_sent < 2 * planned_bytes / 3) begin
            tx_idle_pct = 56;
            rx_idle_pct <= 34;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
        end
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_file_byte   <= b;
        s_end_of_file <= eof;
        do @(posedge aclk); while (!s_ready);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        logic [7:0]  hdr [bmp24_pkg::HDR_BYTES];
        logic [31:0] img_width;
        logic [31:0] img_height;
        logic [31:0] height_field;
        logic [31:0] data_offset;
        logic        top_down;
        file_end_e   ending;
        int          row_bytes;
        int          data_len;
        int          trail_len;

        // Widths stay small enough that the file holds several rows.
        if ($urandom_range(3, 0) == 0)
            img_width = $urandom_range(100, 13);
        else
            img_width = $urandom_range(12, 1);
        row_bytes   = 3 * img_width + (img_width & 3);
        img_height  = (DATA_BUDGET / row_bytes > 0) ? DATA_BUDGET / row_bytes : 1;
        top_down    = 1'($urandom_range(1, 0));
        data_offset = bmp24_pkg::HDR_BYTES + $urandom_range(8, 0);
        ending      = file_end_e'($urandom_range(2, 0));

        // A short file stops on the byte that completes a random pixel of the last
        // row; that byte yields the pixel and, unless it ends the image, the error.
        // It gets one extra row so that its length stays near the budget.
        if (ending == FILE_SHORT) begin
            img_height = img_height + 32'd1;
            data_len   = (img_height - 1) * row_bytes +
                         3 * $urandom_range(img_width - 1, 0) + 3;
        end else begin
            data_len = img_height * row_bytes;
        end
        trail_len     = $urandom_range(5, 1);
        planned_bytes = data_offset + data_len + trail_len;

        height_field = top_down ? 32'd0 - img_height : img_height;
        for (int i = 0; i < bmp24_pkg::HDR_BYTES; i++)
            hdr[i] = 8'($urandom_range(255, 0));
        hdr[0]  = bmp24_pkg::SIGNATURE[7:0];
        hdr[1]  = bmp24_pkg::SIGNATURE[15:8];
        hdr[28] = bmp24_pkg::BIT_DEPTH[7:0];
        hdr[29] = bmp24_pkg::BIT_DEPTH[15:8];
        for (int i = 0; i < 4; i++) begin
            hdr[10 + i] = data_offset[8*i +: 8];
            hdr[18 + i] = img_width[8*i +: 8];
            hdr[22 + i] = height_field[8*i +: 8];
            hdr[30 + i] = 8'h00;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < bmp24_pkg::HDR_BYTES; i++)
            send_byte(hdr[i], 1'b0);
        // Hold the file back until the header result has been taken.
        wait_for_results();
        for (int i = bmp24_pkg::HDR_BYTES; i < data_offset; i++)
            send_byte(8'($urandom_range(255, 0)), 1'b0);
        for (int i = 0; i < data_len; i++)
            send_byte(8'($urandom_range(255, 0)),
                      (i == data_len - 1) && (ending != FILE_TRAILING));
        // Bytes after the image or after an error are consumed silently.
        for (int i = 0; i < trail_len; i++)
            send_byte(8'($urandom_range(255, 0)),
                      (i == trail_len - 1) ? 1'b1 : 1'($urandom_range(1, 0)));

        stim_done <= 1'b1;
        wait_for_results();
        repeat (20) @(posedge aclk);

        $display("Streamed a %0dx%0d %s image at data offset %0d: %0d bytes, ending %s.",
                 img_width, img_height, top_down ? "top-down" : "bottom-up",
                 data_offset, bytes_sent, ending.name());
        $display("Checked %0d results with %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("bmp24_stream_to_pixels_tb: PASS");
        else
            $display("bmp24_stream_to_pixels_tb: FAIL");
        $finish;
    end

endmodule
